FILE: design/cce_pkg.sv
// cce_pkg: shared types, register codes, reset values and width helpers
// for the configurable CRC engine. No dependencies.
`default_nettype none

package cce_pkg;

  localparam int unsigned CrcW    = 32;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned WcodeW  = 2;
  localparam int unsigned CfgIdxW = 3;

  typedef logic [CrcW-1:0]    crc_t;
  typedef logic [ByteW-1:0]   byte_t;
  typedef logic [WcodeW-1:0]  wcode_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_WIDTH_CODE  = 3'd0,
    REG_POLY_VALUE  = 3'd1,
    REG_START_VALUE = 3'd2,
    REG_FINAL_XOR   = 3'd3,
    REG_LSB_FIRST   = 3'd4
  } cfg_idx_t;

  typedef enum logic [WcodeW-1:0] {
    WIDTH_8  = 2'd0,
    WIDTH_16 = 2'd1,
    WIDTH_32 = 2'd2,
    WIDTH_32B = 2'd3
  } width_t;

  localparam wcode_t RstWidthCode  = WIDTH_16;
  localparam crc_t   RstPolyValue  = 32'h0000_1021;
  localparam crc_t   RstStartValue = 32'h0000_FFFF;
  localparam crc_t   RstFinalXor   = 32'h0000_0000;
  localparam logic   RstLsbFirst   = 1'b0;

  // mask of the active CRC width; code three acts as 32 bits
  function automatic crc_t width_mask(input wcode_t wc);
    crc_t m;
    begin
      case (wc)
        WIDTH_8:  m = 32'h0000_00FF;
        WIDTH_16: m = 32'h0000_FFFF;
        default:  m = 32'hFFFF_FFFF;
      endcase
      return m;
    end
  endfunction

endpackage

`default_nettype wire

FILE: design/cce_fold.sv
// cce_fold: folds one byte into the CRC register in eight unrolled bit
// steps, either order, masked to width. Depends on cce_pkg.
`default_nettype none

module cce_fold (
  input  wire cce_pkg::crc_t   crc_in,
  input  wire cce_pkg::byte_t  data_byte,
  input  wire cce_pkg::wcode_t width_code,
  input  wire cce_pkg::crc_t   poly_value,
  input  wire logic            lsb_first,
  output cce_pkg::crc_t        crc_out
);

  cce_pkg::crc_t c;
  logic          tbit;

  always_comb begin
    c    = crc_in;
    tbit = 1'b0;
    if (lsb_first) begin
      c = c ^ {24'd0, data_byte};
      for (int k = 0; k < 8; k++) begin
        tbit = c[0];
        c    = tbit ? ((c >> 1) ^ poly_value) : (c >> 1);
      end
    end else begin
      case (width_code)
        cce_pkg::WIDTH_8:  c = c ^ {24'd0, data_byte};
        cce_pkg::WIDTH_16: c = c ^ {16'd0, data_byte, 8'd0};
        default:           c = c ^ {data_byte, 24'd0};
      endcase
      for (int k = 0; k < 8; k++) begin
        case (width_code)
          cce_pkg::WIDTH_8:  tbit = c[7];
          cce_pkg::WIDTH_16: tbit = c[15];
          default:           tbit = c[31];
        endcase
        c = tbit ? ((c << 1) ^ poly_value) : (c << 1);
      end
    end
    crc_out = c & cce_pkg::width_mask(width_code);
  end

endmodule

`default_nettype wire

FILE: design/configurable_crc_engine.sv
// configurable_crc_engine: byte-stream CRC, 8/16/32 bits, configurable
// polynomial, start value, final xor and bit order.
// A last item's CRC is registered into the result register that drives out_*, or into the skid while out stalls.
// Throughput: one item per cycle while in_stall is low; the eight bit steps are unrolled in cce_fold.
// A two-entry output (result register plus skid) lets input run while out stalls, until the skid holds a result.
// Reset (rst_n low, synchronous): config to defaults, no message open, outputs empty.
`default_nettype none

module configurable_crc_engine (
  input  wire  logic                        clk,
  input  wire  logic                        rst_n,
  input  wire  logic                        in_valid,
  output logic                              in_stall,
  input  wire  cce_pkg::byte_t              in_data_byte,
  input  wire  logic                        in_byte_valid,
  input  wire  logic                        in_last,
  output logic                              out_valid,
  input  wire  logic                        out_stall,
  output cce_pkg::crc_t                     out_crc_value,
  input  wire  logic                        cfg_valid,
  output logic                              cfg_ready,
  input  wire  logic [cce_pkg::CfgIdxW-1:0] cfg_index,
  input  wire  cce_pkg::crc_t               cfg_data
);

  cce_pkg::wcode_t width_code_r;
  cce_pkg::crc_t   poly_value_r;
  cce_pkg::crc_t   start_value_r;
  cce_pkg::crc_t   final_xor_r;
  logic            lsb_first_r;

  cce_pkg::crc_t   crc_r, crc_nxt;
  logic            in_msg_r, in_msg_nxt;
  logic            out_valid_r, out_valid_nxt;
  cce_pkg::crc_t   out_crc_r, out_crc_nxt;
  logic            skid_valid_r, skid_valid_nxt;
  cce_pkg::crc_t   skid_crc_r, skid_crc_nxt;

  cce_pkg::crc_t   mask;
  cce_pkg::crc_t   crc_base;
  cce_pkg::crc_t   crc_folded;
  cce_pkg::crc_t   crc_after;
  cce_pkg::crc_t   result;
  logic            accept;
  logic            push;
  logic            out_free;

  assign cfg_ready     = 1'b1;
  assign in_stall      = skid_valid_r;
  assign out_valid     = out_valid_r;
  assign out_crc_value = out_crc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_code_r  <= cce_pkg::RstWidthCode;
      poly_value_r  <= cce_pkg::RstPolyValue;
      start_value_r <= cce_pkg::RstStartValue;
      final_xor_r   <= cce_pkg::RstFinalXor;
      lsb_first_r   <= cce_pkg::RstLsbFirst;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cce_pkg::REG_WIDTH_CODE:  width_code_r  <= cfg_data[cce_pkg::WcodeW-1:0];
        cce_pkg::REG_POLY_VALUE:  poly_value_r  <= cfg_data;
        cce_pkg::REG_START_VALUE: start_value_r <= cfg_data;
        cce_pkg::REG_FINAL_XOR:   final_xor_r   <= cfg_data;
        cce_pkg::REG_LSB_FIRST:   lsb_first_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign mask     = cce_pkg::width_mask(width_code_r);
  assign crc_base = in_msg_r ? crc_r : (start_value_r & mask);

  cce_fold u_fold (
    .crc_in     (crc_base),
    .data_byte  (in_data_byte),
    .width_code (width_code_r),
    .poly_value (poly_value_r),
    .lsb_first  (lsb_first_r),
    .crc_out    (crc_folded)
  );

  assign accept    = in_valid && !in_stall;
  assign crc_after = in_byte_valid ? crc_folded : crc_base;
  assign result    = (crc_after ^ final_xor_r) & mask;
  assign push      = accept && in_last;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    crc_nxt        = crc_r;
    in_msg_nxt     = in_msg_r;
    out_valid_nxt  = out_valid_r;
    out_crc_nxt    = out_crc_r;
    skid_valid_nxt = skid_valid_r;
    skid_crc_nxt   = skid_crc_r;
    if (accept && (in_byte_valid || in_last)) begin
      crc_nxt    = crc_after;
      in_msg_nxt = !in_last;
    end
    if (out_free) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_crc_nxt    = skid_crc_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = push;
        out_crc_nxt   = result;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_crc_nxt   = result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_msg_r     <= 1'b0;
      crc_r        <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      in_msg_r     <= in_msg_nxt;
      crc_r        <= crc_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_crc_r  <= out_crc_nxt;
    skid_crc_r <= skid_crc_nxt;
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds an item while the result register is empty");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_last && !out_valid_r) |=> (out_valid_r && !skid_valid_r))
    else $error("last item did not reach the result register");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !in_last && !out_valid_r && !skid_valid_r) |=> !out_valid_r)
    else $error("result produced without a last item");

  a_last_closes_msg: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_last) |=> !in_msg_r)
    else $error("message still open after last item");

endmodule

`default_nettype wire
